[src/acal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package acal_pkg;

    // Commands carried in the input word
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_CAL   = 2'd1;
    localparam logic [1:0] CMD_MEAS  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_MEAS        = 2'd0;
    localparam logic [1:0] ST_CALIBRATING = 2'd1;
    localparam logic [1:0] ST_CAL_DONE    = 2'd2;
    localparam logic [1:0] ST_CLEARED     = 2'd3;

    // Configuration register indexes
    localparam logic REG_GAIN           = 1'b0;
    localparam logic REG_OFFSET_SAMPLES = 1'b1;

    localparam logic [23:0] GAIN_RESET           = 24'd65536;
    localparam logic [15:0] OFFSET_SAMPLES_RESET = 16'd100;

    // Field and state widths
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 24;
    localparam int OSMP_W   = 16;
    localparam int SUM_W    = 28;
    localparam int OFF_W    = 20;
    localparam int CUR_W    = 32;

    // Shared divider: two quotient bits per cycle
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] numer;
        logic [DIV_DEN_W-1:0] denom;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[src/adc_current_offset_calibrate_average_unit.sv]
// Multi-channel current-sensor conditioner with per-channel offset
// calibration and a three-tap moving average of the converted current.
// Input channel (i_in_valid / o_in_ready) takes one word per item: a command
// (clear, calibration sample, measurement sample), a channel and a raw sample.
// Every item produces exactly one result word on the output channel
// (o_out_valid / i_out_ready): channel, averaged current, status, calibrated.
// Configuration (i_cfg_valid / o_cfg_ready) writes gain and sample count; the
// port is always ready and must be written only while the block is idle.
// One item at a time; the block is busy until its result sits in the output
// register. A clear, an unfinished calibration sample or a missing channel goes
// from decode straight to the result; the sample that finishes calibration
// takes one division, and a measurement takes one multiply, then two passes
// through the shared two-bit-per-cycle divider: divide by ten, then divide by
// three. The next word is accepted in the cycle after the result is loaded.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and processed and waits before its result is loaded.
// Reset (synchronous, active low) clears all sums, counts, offsets, flags and
// histories at once and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module adc_current_offset_calibrate_average_unit #(
    parameter int CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [2:0]  i_channel,
    input  wire logic [11:0] i_sample,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_out_channel,
    output logic signed [31:0] o_current,
    output logic [1:0]       o_status,
    output logic             o_calibrated,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_EXT_W = CH_IDX_W + 3;
    localparam int SHIFT    = 8 + acal_pkg::SAMPLE_W;
    localparam int MAG_W    = acal_pkg::OFF_W + 1;
    localparam int MAG33_W  = MAG_W + 6;
    localparam int PROD_W   = MAG33_W + acal_pkg::GAIN_W;
    localparam int NUM_W    = acal_pkg::DIV_NUM_W;
    localparam int DEN_W    = acal_pkg::DIV_DEN_W;
    localparam int SUM_W    = acal_pkg::SUM_W;
    localparam int OFF_W    = acal_pkg::OFF_W;
    localparam int CUR_W    = acal_pkg::CUR_W;
    localparam int TOT_W    = CUR_W + 2;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_Q10      = 4'd3;
    localparam logic [3:0] S_Q10_WAIT = 4'd4;
    localparam logic [3:0] S_AVG      = 4'd5;
    localparam logic [3:0] S_AVG_WAIT = 4'd6;
    localparam logic [3:0] S_CAL_WAIT = 4'd7;
    localparam logic [3:0] S_RES      = 4'd8;

    logic [3:0]  r_state;
    logic [3:0]  n_state;

    // Latched input word
    logic [1:0]  r_cmd;
    logic [2:0]  r_ch;
    logic [11:0] r_sample;

    // Configuration registers
    logic [acal_pkg::GAIN_W-1:0] r_gain;
    logic [acal_pkg::OSMP_W-1:0] r_osmp;

    // Per-channel state
    logic [SUM_W-1:0]          r_sum [CHANNELS];
    logic [15:0]               r_cnt [CHANNELS];
    logic [OFF_W-1:0]          r_off [CHANNELS];
    logic [CHANNELS-1:0]       r_cal;

    // History memory: {older, old} per channel, valid bit reads as zero
    logic [2*CUR_W-1:0]        r_hist_mem [CHANNELS];
    logic [CHANNELS-1:0]       r_hist_vld;
    logic [2*CUR_W-1:0]        r_hist_rd;
    logic                      r_hist_rd_vld;

    // Datapath registers
    logic                      r_neg;
    logic [MAG33_W-1:0]        r_mag33;
    logic [PROD_W-1:0]         r_prod;
    logic signed [CUR_W-1:0]   r_now;
    logic                      r_tneg;

    // Pending result
    logic signed [CUR_W-1:0]   r_res_cur;
    logic [1:0]                r_res_st;
    logic                      r_res_cal;

    // Output register
    logic                      r_out_valid;
    logic [2:0]                r_out_ch;
    logic signed [CUR_W-1:0]   r_out_cur;
    logic [1:0]                r_out_st;
    logic                      r_out_cal;

    acal_pkg::t_div_req        w_div_req;
    acal_pkg::t_div_rsp        w_div_rsp;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic [CH_EXT_W-1:0]       w_ch_ext;
    logic [CH_IDX_W-1:0]       w_idx;
    logic                      w_exists;
    logic [SUM_W-1:0]          w_sum_new;
    logic [15:0]               w_cnt_new;
    logic [15:0]               w_target;
    logic                      w_cal_fin;
    logic [OFF_W-1:0]          w_off_sel;
    logic signed [MAG_W-1:0]   w_diff;
    logic [MAG_W-1:0]          w_mag;
    logic [MAG33_W-1:0]        w_mag33;
    logic signed [CUR_W-1:0]   w_sat;
    logic signed [CUR_W-1:0]   w_older;
    logic signed [CUR_W-1:0]   w_old;
    logic signed [TOT_W-1:0]   w_total;
    logic [TOT_W-1:0]          w_tmag;

    acal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_RES) && (!r_out_valid || i_out_ready);

    // Channel decode
    always_comb begin
        w_ch_ext = CH_EXT_W'(r_ch);
        w_idx    = w_ch_ext[CH_IDX_W-1:0];
        w_exists = w_ch_ext < CH_EXT_W'(CHANNELS);
    end

    // Calibration accumulate; the count saturates at its ceiling
    always_comb begin
        w_sum_new = r_sum[w_idx] + SUM_W'(r_sample);
        w_cnt_new = (r_cnt[w_idx] != 16'hFFFF) ? r_cnt[w_idx] + 16'd1 : r_cnt[w_idx];
        w_target  = (r_osmp == '0) ? 16'd1 : r_osmp;
        w_cal_fin = w_cnt_new >= w_target;
    end

    // Offset-corrected magnitude times 33 (shift and add)
    always_comb begin
        w_off_sel = r_cal[w_idx] ? r_off[w_idx] : '0;
        w_diff    = $signed({1'b0, r_sample, 8'b0}) - $signed({1'b0, w_off_sel});
        w_mag     = w_diff[MAG_W-1] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
        w_mag33   = (MAG33_W'(w_mag) << 5) + MAG33_W'(w_mag);
    end

    // Saturate the scaled quotient to the signed 32-bit range
    always_comb begin
        if (r_neg) begin
            if (w_div_rsp.quot > NUM_W'(64'h8000_0000)) begin
                w_sat = 32'sh8000_0000;
            end else begin
                w_sat = -$signed(w_div_rsp.quot[CUR_W-1:0]);
            end
        end else begin
            if (w_div_rsp.quot > NUM_W'(64'h7FFF_FFFF)) begin
                w_sat = 32'sh7FFF_FFFF;
            end else begin
                w_sat = $signed(w_div_rsp.quot[CUR_W-1:0]);
            end
        end
    end

    // Three-tap sum and its magnitude
    always_comb begin
        w_older = r_hist_rd_vld ? $signed(r_hist_rd[2*CUR_W-1:CUR_W]) : '0;
        w_old   = r_hist_rd_vld ? $signed(r_hist_rd[CUR_W-1:0]) : '0;
        w_total = TOT_W'(w_older) + TOT_W'(w_old) + TOT_W'(r_now);
        w_tmag  = w_total[TOT_W-1] ? TOT_W'(-w_total) : TOT_W'(w_total);
    end

    // Shared divider requests
    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.numer = {w_sum_new, 8'b0};
        w_div_req.denom = w_cnt_new;
        case (r_state)
            S_DEC: begin
                w_div_req.start = (r_cmd == acal_pkg::CMD_CAL) && w_exists && w_cal_fin;
            end
            S_Q10: begin
                w_div_req.start = 1'b1;
                w_div_req.numer = NUM_W'(r_prod >> SHIFT);
                w_div_req.denom = DEN_W'(10);
            end
            S_AVG: begin
                w_div_req.start = 1'b1;
                w_div_req.numer = NUM_W'(w_tmag);
                w_div_req.denom = DEN_W'(3);
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_DEC;
            end
            S_DEC: begin
                case (r_cmd)
                    acal_pkg::CMD_CLEAR: n_state = S_RES;
                    acal_pkg::CMD_CAL: begin
                        n_state = (w_exists && w_cal_fin) ? S_CAL_WAIT : S_RES;
                    end
                    default: n_state = w_exists ? S_MUL : S_RES;
                endcase
            end
            S_MUL:      n_state = S_Q10;
            S_Q10:      n_state = S_Q10_WAIT;
            S_Q10_WAIT: begin
                if (w_div_rsp.done) n_state = S_AVG;
            end
            S_AVG:      n_state = S_AVG_WAIT;
            S_AVG_WAIT: begin
                if (w_div_rsp.done) n_state = S_RES;
            end
            S_CAL_WAIT: begin
                if (w_div_rsp.done) n_state = S_RES;
            end
            S_RES: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= acal_pkg::GAIN_RESET;
            r_osmp <= acal_pkg::OFFSET_SAMPLES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                acal_pkg::REG_GAIN:           r_gain <= i_cfg_data;
                acal_pkg::REG_OFFSET_SAMPLES: r_osmp <= i_cfg_data[15:0];
                default:                      r_gain <= r_gain;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_cmd;
            r_ch     <= i_channel;
            r_sample <= i_sample;
        end
    end

    // Per-channel calibration state; clear wipes every channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
                r_off[i] <= '0;
            end
            r_cal      <= '0;
            r_hist_vld <= '0;
        end else begin
            if (r_state == S_DEC) begin
                if (r_cmd == acal_pkg::CMD_CLEAR) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        r_sum[i] <= '0;
                        r_cnt[i] <= '0;
                        r_off[i] <= '0;
                    end
                    r_cal      <= '0;
                    r_hist_vld <= '0;
                end else if (r_cmd == acal_pkg::CMD_CAL && w_exists) begin
                    // restart the channel once its count is reached
                    r_sum[w_idx] <= w_cal_fin ? '0 : w_sum_new;
                    r_cnt[w_idx] <= w_cal_fin ? '0 : w_cnt_new;
                end
            end
            if (r_state == S_CAL_WAIT && w_div_rsp.done) begin
                r_off[w_idx]      <= w_div_rsp.quot[OFF_W-1:0];
                r_cal[w_idx]      <= 1'b1;
                r_hist_vld[w_idx] <= 1'b0;
            end
            if (r_state == S_AVG) begin
                r_hist_vld[w_idx] <= 1'b1;
            end
        end
    end

    // History memory: read in decode, write back the shifted pair
    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC && w_exists) begin
            r_hist_rd     <= r_hist_mem[w_idx];
            r_hist_rd_vld <= r_hist_vld[w_idx];
        end
        if (r_state == S_AVG) begin
            r_hist_mem[w_idx] <= {w_old, r_now};
        end
    end

    // Measurement datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC) begin
            r_neg   <= w_diff[MAG_W-1];
            r_mag33 <= w_mag33;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_mag33 * r_gain;
        end
        if (r_state == S_Q10_WAIT && w_div_rsp.done) begin
            r_now <= w_sat;
        end
        if (r_state == S_AVG) begin
            r_tneg <= w_total[TOT_W-1];
        end
    end

    // Pending result fields; a clear always reports the channel uncalibrated
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_DEC: begin
                r_res_cur <= '0;
                r_res_cal <= (r_cmd != acal_pkg::CMD_CLEAR) && w_exists && r_cal[w_idx];
                case (r_cmd)
                    acal_pkg::CMD_CLEAR: r_res_st <= acal_pkg::ST_CLEARED;
                    acal_pkg::CMD_CAL:   r_res_st <= acal_pkg::ST_CALIBRATING;
                    default:             r_res_st <= acal_pkg::ST_MEAS;
                endcase
            end
            S_CAL_WAIT: begin
                if (w_div_rsp.done) begin
                    r_res_st  <= acal_pkg::ST_CAL_DONE;
                    r_res_cal <= 1'b1;
                end
            end
            S_AVG_WAIT: begin
                if (w_div_rsp.done) begin
                    r_res_cur <= r_tneg ? -$signed(w_div_rsp.quot[CUR_W-1:0])
                                        : $signed(w_div_rsp.quot[CUR_W-1:0]);
                end
            end
            default: begin
                r_res_cur <= r_res_cur;
            end
        endcase
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ch  <= r_ch;
            r_out_cur <= r_res_cur;
            r_out_st  <= r_res_st;
            r_out_cal <= r_res_cal;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_current     = r_out_cur;
    assign o_status      = r_out_st;
    assign o_calibrated  = r_out_cal;

endmodule

`default_nettype wire

[src/acal_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, two quotient bits per cycle.
module acal_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acal_pkg::t_div_req i_req,
    output acal_pkg::t_div_rsp      o_rsp
);

    localparam int NUM_W = acal_pkg::DIV_NUM_W;
    localparam int DEN_W = acal_pkg::DIV_DEN_W;
    localparam int CNT_W = acal_pkg::DIV_CNT_W;

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DEN_W:0]   w_t1;
    logic [DEN_W:0]   w_t2;
    logic             w_ge1;
    logic             w_ge2;
    logic [DEN_W-1:0] w_r1;
    logic [DEN_W-1:0] w_r2;

    always_comb begin
        w_t1  = {r_rem, r_num[NUM_W-1]};
        w_ge1 = w_t1 >= {1'b0, r_den};
        w_r1  = w_ge1 ? DEN_W'(w_t1 - {1'b0, r_den}) : w_t1[DEN_W-1:0];
        w_t2  = {w_r1, r_num[NUM_W-2]};
        w_ge2 = w_t2 >= {1'b0, r_den};
        w_r2  = w_ge2 ? DEN_W'(w_t2 - {1'b0, r_den}) : w_t2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= CNT_W'(acal_pkg::DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.numer;
            r_den <= i_req.denom;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            // shift quotient bits in at the bottom
            r_num <= {r_num[NUM_W-3:0], w_ge1, w_ge2};
            r_rem <= w_r2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

`default_nettype wire

[test/adc_current_result_checker.sv]
`timescale 1ns / 1ps

module adc_current_result_checker
    import acal_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [2:0]  i_channel,
    input  wire logic [11:0] i_sample,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  i_out_channel,
    input  wire logic signed [31:0] i_current,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_calibrated,

    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data,

    output int               o_fail_count,
    output int               o_pending,
    output int               o_words_checked,
    output int               o_cal_done,
    output int               o_clears
);

    localparam int NUM_CH   = 8;
    localparam int ADC_BITS = 12;

    typedef struct packed {
        logic [2:0]         chan;
        logic signed [31:0] amps;
        logic [1:0]         status;
        logic               calibrated;
    } t_conditioned_word;

    // Shadow state of the conditioner
    logic [OFF_W-1:0]   offset_q8  [NUM_CH];
    logic [SUM_W-1:0]   cal_sum    [NUM_CH];
    logic [OSMP_W-1:0]  cal_cnt    [NUM_CH];
    logic signed [31:0] amps_prev2 [NUM_CH];
    logic signed [31:0] amps_prev1 [NUM_CH];
    logic               cal_flag   [NUM_CH];
    logic [GAIN_W-1:0]  gain_reg;
    logic [OSMP_W-1:0]  nsamp_reg;

    t_conditioned_word expected_words[$];

    int fail_cnt;
    int checked_cnt;
    int cal_done_cnt;
    int clear_cnt;

    function automatic void wipe_channels();
        for (int c = 0; c < NUM_CH; c++) begin
            offset_q8[c]  = '0;
            cal_sum[c]    = '0;
            cal_cnt[c]    = '0;
            amps_prev2[c] = '0;
            amps_prev1[c] = '0;
            cal_flag[c]   = 1'b0;
        end
    endfunction

    // Scale a Q12.8 count difference to Q16.16 amperes, truncate, saturate
    function automatic logic signed [31:0] counts_to_amps(input longint diff);
        longint unsigned mag;
        longint unsigned q;
        mag = (diff < 0) ? -diff : diff;
        q = (mag * 64'd33 * gain_reg) / (64'd10 << (8 + ADC_BITS));
        if (diff < 0) begin
            if (q > 64'd2147483648) q = 64'd2147483648;
            return 32'(-longint'(q));
        end
        if (q > 64'd2147483647) q = 64'd2147483647;
        return 32'(q);
    endfunction

    function automatic t_conditioned_word predict_conditioned_word(
        input logic [1:0] cmd, input logic [2:0] ch, input logic [11:0] smp);
        t_conditioned_word w;
        logic [OSMP_W-1:0] target;
        logic [35:0]       numer;
        longint            diff;
        longint            total;
        logic signed [31:0] now_amps;
        w = '0;
        w.chan = ch;
        case (cmd)
            CMD_CLEAR: begin
                wipe_channels();
                w.status = ST_CLEARED;
            end
            CMD_CAL: begin
                w.status = ST_CALIBRATING;
                target = (nsamp_reg == '0) ? OSMP_W'(1) : nsamp_reg;
                cal_sum[ch] = cal_sum[ch] + smp;
                if (cal_cnt[ch] != '1) cal_cnt[ch] = cal_cnt[ch] + 1'b1;
                if (cal_cnt[ch] >= target) begin
                    numer = {cal_sum[ch], 8'd0};
                    offset_q8[ch]  = OFF_W'(numer / cal_cnt[ch]);
                    cal_sum[ch]    = '0;
                    cal_cnt[ch]    = '0;
                    amps_prev2[ch] = '0;
                    amps_prev1[ch] = '0;
                    cal_flag[ch]   = 1'b1;
                    w.status = ST_CAL_DONE;
                end
            end
            default: begin
                // the unused code decodes as a measurement
                w.status = ST_MEAS;
                diff = longint'({smp, 8'd0})
                     - (cal_flag[ch] ? longint'(offset_q8[ch]) : 64'sd0);
                now_amps = counts_to_amps(diff);
                total = longint'(amps_prev2[ch]) + longint'(amps_prev1[ch])
                      + longint'(now_amps);
                w.amps = 32'(total / 3);
                amps_prev2[ch] = amps_prev1[ch];
                amps_prev1[ch] = now_amps;
            end
        endcase
        w.calibrated = cal_flag[ch];
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_conditioned_word seen;
        t_conditioned_word want;
        if (!i_rst_n) begin
            wipe_channels();
            gain_reg  = GAIN_RESET;
            nsamp_reg = OFFSET_SAMPLES_RESET;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_GAIN) gain_reg = i_cfg_data;
                else nsamp_reg = i_cfg_data[OSMP_W-1:0];
            end
            // compare first: a word leaving now belongs to an older item
            if (i_out_valid && i_out_ready) begin
                seen = '{i_out_channel, i_current, i_status, i_calibrated};
                if (expected_words.size() == 0) begin
                    $error("result word with no item outstanding: ch %0d cur %0d st %0d",
                           seen.chan, seen.amps, seen.status);
                    fail_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    checked_cnt++;
                    if (seen.chan !== want.chan) begin
                        $error("out_channel: expected %0d, got %0d", want.chan, seen.chan);
                        fail_cnt++;
                    end
                    if (seen.amps !== want.amps) begin
                        $error("current: expected %0d, got %0d", want.amps, seen.amps);
                        fail_cnt++;
                    end
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        fail_cnt++;
                    end
                    if (seen.calibrated !== want.calibrated) begin
                        $error("calibrated: expected %0d, got %0d",
                               want.calibrated, seen.calibrated);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = predict_conditioned_word(i_cmd, i_channel, i_sample);
                if (want.status == ST_CAL_DONE) cal_done_cnt++;
                if (want.status == ST_CLEARED) clear_cnt++;
                expected_words.push_back(want);
            end
        end
        o_fail_count    <= fail_cnt;
        o_pending       <= expected_words.size();
        o_words_checked <= checked_cnt;
        o_cal_done      <= cal_done_cnt;
        o_clears        <= clear_cnt;
    end

    initial begin
        fail_cnt     = 0;
        checked_cnt  = 0;
        cal_done_cnt = 0;
        clear_cnt    = 0;
    end

endmodule

[test/adc_current_offset_calibrate_average_unit_tb.sv]
`timescale 1ns / 1ps

module adc_current_offset_calibrate_average_unit_tb;
    import acal_pkg::*;

    // cmd code 3 is unused and must decode as a measurement
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // a measurement occupies the block longest; leave margin before config writes
    localparam int SETTLE_CYCLES = 60;
    localparam int RUN_LIMIT_NS  = 3_000_000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_cmd       = CMD_CLEAR;
    logic [2:0]  i_channel   = '0;
    logic [11:0] i_sample    = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = REG_GAIN;
    logic [23:0] i_cfg_data  = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [2:0]        o_out_channel;
    logic signed [31:0] o_current;
    logic [1:0]        o_status;
    logic              o_calibrated;
    logic              o_cfg_ready;

    int fail_count;
    int pending_words;
    int words_checked;
    int cal_done_count;
    int clear_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;

    adc_current_offset_calibrate_average_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_channel (o_out_channel),
        .o_current     (o_current),
        .o_status      (o_status),
        .o_calibrated  (o_calibrated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    adc_current_result_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_channel       (i_channel),
        .i_sample        (i_sample),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_channel   (o_out_channel),
        .i_current       (o_current),
        .i_status        (o_status),
        .i_calibrated    (o_calibrated),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_words_checked (words_checked),
        .o_cal_done      (cal_done_count),
        .o_clears        (clear_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one word; idle first at the phase rate, then hold until accepted.
    // Valid only drops when a gap is taken, so it never toggles within a step.
    task automatic send_word(input logic [1:0] cmd, input logic [2:0] chan,
                             input logic [11:0] smp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_channel  <= chan;
        i_sample   <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // Drop valid and hold until every outstanding result word has come back.
    // Step one edge first so an item accepted at this edge is counted.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    // Write both registers while the block is idle
    task automatic load_config(input logic [23:0] gain, input logic [15:0] count);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_GAIN;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_OFFSET_SAMPLES;
        i_cfg_data  <= {8'd0, count};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly calibration and measurement traffic, rare clears so that
    // channels get to finish calibration and build up a history
    task automatic send_random_word();
        int          pick;
        logic [1:0]  cmd;
        logic [11:0] smp;
        pick = $urandom_range(199);
        if (pick < 3) cmd = CMD_CLEAR;
        else if (pick < 80) cmd = CMD_CAL;
        else if (pick < 190) cmd = CMD_MEAS;
        else cmd = CMD_UNUSED;
        case ($urandom_range(7))
            0: smp = 12'd0;
            1: smp = 12'hFFF;
            default: smp = 12'($urandom_range(4095));
        endcase
        send_word(cmd, 3'($urandom_range(7)), smp);
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                             input int pause_at);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++) begin
            // pause the sender until the block has fully caught up
            if (n == pause_at) drain_results();
            send_random_word();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: register defaults, channels uncalibrated (offset zero)
        send_word(CMD_MEAS, 3'd0, 12'd0);
        send_word(CMD_MEAS, 3'd0, 12'hFFF);
        send_word(CMD_UNUSED, 3'd1, 12'd2048);
        // clear ignores the channel field
        send_word(CMD_CLEAR, 3'd7, 12'hFFF);

        // Max gain, sample count of zero behaves as one
        load_config(24'hFFFFFF, 16'd0);
        send_word(CMD_CAL, 3'd2, 12'hFFF);
        send_word(CMD_MEAS, 3'd2, 12'd0);
        send_word(CMD_MEAS, 3'd2, 12'hFFF);
        send_word(CMD_MEAS, 3'd7, 12'd0);

        // Zero gain, max sample count: calibration stays open
        load_config(24'd0, 16'hFFFF);
        send_word(CMD_CAL, 3'd5, 12'd100);
        send_word(CMD_CAL, 3'd5, 12'd200);
        send_word(CMD_CAL, 3'd5, 12'd301);
        send_word(CMD_MEAS, 3'd5, 12'd1234);

        // Lower the count below the running count: next sample finishes it
        load_config(GAIN_RESET, 16'd2);
        send_word(CMD_CAL, 3'd5, 12'd7);
        send_word(CMD_MEAS, 3'd5, 12'd0);
        send_word(CMD_MEAS, 3'd5, 12'hFFF);
        send_word(CMD_MEAS, 3'd5, 12'd2000);
        send_word(CMD_CAL, 3'd3, 12'd0);
        send_word(CMD_CAL, 3'd3, 12'd0);
        send_word(CMD_CLEAR, 3'd3, 12'd0);
        send_word(CMD_MEAS, 3'd3, 12'hFFF);

        // Random phases, each under its own register setting
        load_config(GAIN_RESET, 16'd3);
        run_phase(140, 0, 0, -1);
        load_config(24'hFFFFFF, 16'd1);
        run_phase(140, 47, 0, -1);
        load_config(24'($urandom_range(24'hFFFFFF)), 16'($urandom_range(6, 2)));
        run_phase(140, 0, 47, -1);
        load_config(24'($urandom_range(24'hFFFFFF)), 16'd4);
        run_phase(140, 27, 27, 70);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d items, checked %0d result words", words_sent, words_checked);
        $display("%0d calibrations finished, %0d clears, under 8 register settings",
                 cal_done_count, clear_count);
        if (fail_count == 0 && pending_words == 0) begin
            $display("adc_current_offset_calibrate_average_unit regression: pass");
        end else begin
            $display("adc_current_offset_calibrate_average_unit regression: fail");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d result words outstanding", pending_words);
        $display("adc_current_offset_calibrate_average_unit regression: fail");
        $finish;
    end

endmodule

[filelist.f]
src/acal_pkg.sv
src/acal_div.sv
src/adc_current_offset_calibrate_average_unit.sv
test/adc_current_result_checker.sv
test/adc_current_offset_calibrate_average_unit_tb.sv
